@@ sv/rgb_to_hsv_defines.svh @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_defines.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_DEFINES_SVH
`define RGB_TO_HSV_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define RTH_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rgb_to_hsv assertion failed");

// implication: when pre holds, post holds at the same edge
`define RTH_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rgb_to_hsv implication failed");

// implication: when pre holds, post holds at the next edge
`define RTH_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rgb_to_hsv sequence failed");

`endif

@@ sv/rth_pkg.sv @@
// ----------------------------------------------------------------------------
// rth_pkg
// types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rth_pkg;

    // quotient bits, dividend bits, divisor bits
    localparam int QW = 15;
    localparam int NW = 24;
    localparam int DW = 9;

    localparam logic [QW-1:0] HUE_FULL = 15'd23040;
    localparam logic [NW-1:0] HUE_SCALE2 = 24'd7680;   // two sextants
    localparam logic [NW-1:0] PCT_SCALE2 = 24'd51200;  // two full scales

    // value is 100*max plus round(100*max/255), the latter by reciprocal
    localparam logic [NW-1:0] VAL_SCALE = 24'd100;
    localparam logic [QW-1:0] VAL_ROUND = 15'd127;
    localparam logic [31:0]   VAL_RECIP = 32'd65794;   // 2^24/255 rounded up

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [14:0] saturation;
        logic [14:0] brightness;
        logic        hue_undefined;
    } hsv_t;

    typedef struct packed {
        logic gray;
        logic black;
    } rth_flags_t;

endpackage

@@ sv/rth_prep.sv @@
// ----------------------------------------------------------------------------
// rth_prep
// max, min and delta of a pixel, and the dividends and divisors
// ----------------------------------------------------------------------------
module rth_prep
    import rth_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  pixel_t              pixel,
    output logic                valid_reg,
    output logic [NW-1:0]       a_hue_reg,
    output logic [DW-1:0]       b_hue_reg,
    output logic [NW-1:0]       a_sat_reg,
    output logic [DW-1:0]       b_sat_reg,
    output logic [NW-1:0]       a_val_reg,
    output rth_flags_t          flags_reg
);

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [10:0] k;
    logic [10:0] d11;

    // largest and smallest channel
    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx) mx = pixel.green;
        if (pixel.blue > mx) mx = pixel.blue;
        if (pixel.green < mn) mn = pixel.green;
        if (pixel.blue < mn) mn = pixel.blue;
        d = mx - mn;
    end

    // hue numerator in sextant units, ties go red then green then blue
    always_comb
    begin
        d11 = {3'b0, d};
        if (mx == pixel.red)
        begin
            if (pixel.green >= pixel.blue)
                k = {3'b0, pixel.green} - {3'b0, pixel.blue};
            else
                k = 11'(6 * d11) - ({3'b0, pixel.blue} - {3'b0, pixel.green});
        end
        else if (mx == pixel.green)
            k = 11'(2 * d11) + {3'b0, pixel.blue} - {3'b0, pixel.red};
        else
            k = 11'(4 * d11) + {3'b0, pixel.red} - {3'b0, pixel.green};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    // payload: dividends carry the rounding half term
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_hue_reg       <= {13'b0, k} * HUE_SCALE2 + {16'b0, d};
            b_hue_reg       <= {d, 1'b0};
            a_sat_reg       <= {16'b0, d} * PCT_SCALE2 + {16'b0, mx};
            b_sat_reg       <= {mx, 1'b0};
            a_val_reg       <= {16'b0, mx} * VAL_SCALE + {9'b0, VAL_ROUND};
            flags_reg.gray  <= (d == 8'd0);
            flags_reg.black <= (mx == 8'd0);
        end
    end

endmodule

@@ sv/rth_div.sv @@
// ----------------------------------------------------------------------------
// rth_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rth_div
    import rth_pkg::*;
(
    input  logic          clk,
    input  logic          advance,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int SH = QW - 1 - j;
        logic [NW-1:0] rem_src;
        logic [DW-1:0] den_src;
        logic [QW-1:0] quo_src;
        logic [NW-1:0] trial;
        logic          take;

        // source is the port for the first stage, the stage before otherwise
        if (j == 0)
        begin : g_first
            assign rem_src = num;
            assign den_src = den;
            assign quo_src = '0;
        end
        else
        begin : g_next
            assign rem_src = rem_reg[j-1];
            assign den_src = den_reg[j-1];
            assign quo_src = quo_reg[j-1];
        end

        // compare and subtract the shifted divisor
        assign trial = NW'(den_src) << SH;
        assign take  = (rem_src >= trial);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j] <= take ? (rem_src - trial) : rem_src;
                den_reg[j] <= den_src;
                quo_reg[j] <= quo_src | (QW'(take) << SH);
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

@@ sv/rgb_to_hsv.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv
// rgb pixel to hue, saturation and value in fixed point
// ----------------------------------------------------------------------------
// channel  handshake                 word
// pixel    pixel_valid / pixel_stall  pixel_t: red, green, blue
// hsv      hsv_valid / hsv_stall      hsv_t: hue, saturation, brightness, flag
//
// one word per cycle while no result waits; one prep stage, 15 divider stages
// (one quotient bit each), one output stage; value is formed by a reciprocal
// multiply in the first divider stage and then delayed alongside
// the whole pipeline advances together; it holds while a result waits
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module rgb_to_hsv
    import rth_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   hsv_valid,
    input  logic   hsv_stall,
    output hsv_t   hsv
);

    logic          advance;
    logic          prep_valid;
    logic [NW-1:0] a_hue;
    logic [DW-1:0] b_hue;
    logic [NW-1:0] a_sat;
    logic [DW-1:0] b_sat;
    logic [NW-1:0] a_val;
    rth_flags_t    prep_flags;
    logic [QW-1:0] q_hue;
    logic [QW-1:0] q_sat;
    logic [31:0]   val_prod;
    logic [QW-1:0] val_first;
    logic [QW-1:0] val_reg [QW];
    logic          div_valid_reg [QW];
    rth_flags_t    div_flags_reg [QW];
    logic          hsv_valid_reg;
    hsv_t          hsv_reg;
    hsv_t          hsv_next;

    // global advance
    assign advance     = !(hsv_valid_reg && hsv_stall);
    assign pixel_stall = !advance;

    rth_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (pixel_valid),
        .pixel     (pixel),
        .valid_reg (prep_valid),
        .a_hue_reg (a_hue),
        .b_hue_reg (b_hue),
        .a_sat_reg (a_sat),
        .b_sat_reg (b_sat),
        .a_val_reg (a_val),
        .flags_reg (prep_flags)
    );

    rth_div u_div_hue (.clk(clk), .advance(advance), .num(a_hue), .den(b_hue), .quo(q_hue));
    rth_div u_div_sat (.clk(clk), .advance(advance), .num(a_sat), .den(b_sat), .quo(q_sat));

    // value: 100*max plus (100*max + 127) / 255 by reciprocal multiply
    assign val_prod  = {17'b0, a_val[QW-1:0]} * VAL_RECIP;
    assign val_first = a_val[QW-1:0] - VAL_ROUND + {7'b0, val_prod[31:24]};

    // valid bits alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
                div_valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            div_valid_reg[0] <= prep_valid;
            for (int i = 1; i < QW; i++)
                div_valid_reg[i] <= div_valid_reg[i-1];
        end
    end

    // special-case flags and value alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_flags_reg[0] <= prep_flags;
            val_reg[0]       <= val_first;
            for (int i = 1; i < QW; i++)
            begin
                div_flags_reg[i] <= div_flags_reg[i-1];
                val_reg[i]       <= val_reg[i-1];
            end
        end
    end

    // hue wrap, gray and black overrides
    always_comb
    begin
        hsv_next.hue           = q_hue;
        if (div_flags_reg[QW-1].gray)
            hsv_next.hue = '0;
        else if (q_hue >= HUE_FULL)
            hsv_next.hue = q_hue - HUE_FULL;
        hsv_next.saturation    = div_flags_reg[QW-1].black ? '0 : q_sat;
        hsv_next.brightness    = val_reg[QW-1];
        hsv_next.hue_undefined = div_flags_reg[QW-1].gray;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hsv_valid_reg <= 1'b0;
        else if (advance)
            hsv_valid_reg <= div_valid_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            hsv_reg <= hsv_next;
    end

    assign hsv_valid = hsv_valid_reg;
    assign hsv       = hsv_reg;

endmodule

@@ sv/rth_checker.sv @@
// ----------------------------------------------------------------------------
// rth_checker
// port-level checks of the rgb to hsv converter
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_defines.svh"

module rth_checker
    import rth_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pixel_stall,
    input logic   hsv_valid,
    input logic   hsv_stall,
    input hsv_t   hsv
);

    // a held result keeps its word
    `RTH_ASSERT_NXT(a_hold, hsv_valid && hsv_stall, hsv_valid && $stable(hsv))

    // input only backs up behind a waiting result
    `RTH_ASSERT_IMP(a_stall, pixel_stall, hsv_valid && hsv_stall)

    // hue stays below a full circle
    `RTH_ASSERT_IMP(a_hue, hsv_valid, hsv.hue < 15'd23040)

    // gray pixels give zero hue, and percentages stay in range
    `RTH_ASSERT_IMP(a_range, hsv_valid,
        (!hsv.hue_undefined || hsv.hue == 15'd0) && hsv.saturation <= 15'd25600 &&
        hsv.brightness <= 15'd25600)

endmodule

bind rgb_to_hsv rth_checker u_rth_checker (.*);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks the rgb to hsv converter against an integer model of the conversion
// ----------------------------------------------------------------------------
// pixels go in through the pixel channel with random idle and stall patterns;
// each result word is compared field by field with the oldest predicted word
// ----------------------------------------------------------------------------
module tb;
    import rth_pkg::*;

    localparam int LATENCY = 17;
    localparam int WATCHDOG_LIMIT = 20000;

    logic   clk;
    logic   rst_n;
    logic   pixel_valid;
    logic   pixel_stall;
    pixel_t pixel;
    logic   hsv_valid;
    logic   hsv_stall;
    hsv_t   hsv;

    hsv_t   expected_hsv[$];
    int     error_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;
    int     quiet_cycles = 0;

    rgb_to_hsv dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hsv         (hsv)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // rounded quotient, halves up
    function automatic int unsigned div_round(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    // predicted hsv word for one pixel
    function automatic hsv_t convert_pixel(pixel_t px);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned d;
        int unsigned num;
        int unsigned h;
        hsv_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        h = 0;
        res.hue_undefined = (d == 0);
        if (d != 0)
        begin
            if (mx == r)
                num = (g >= b) ? 3840 * (g - b) : 23040 * d - 3840 * (b - g);
            else if (mx == g)
                num = 7680 * d + 3840 * b - 3840 * r;
            else
                num = 15360 * d + 3840 * r - 3840 * g;
            h = div_round(num, d);
            if (h >= 23040) h -= 23040;
        end
        res.hue = h[14:0];
        res.saturation = (mx != 0) ? 15'(div_round(25600 * d, mx)) : 15'd0;
        res.brightness = 15'(div_round(25600 * mx, 255));
        return res;
    endfunction

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hsv_stall <= 1'b1;
        else
            hsv_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        hsv_t exp_word;
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (expected_hsv.size() == 0)
            begin
                $display("%0t: unexpected word, actual %p", $time, hsv);
                error_count++;
            end
            else
            begin
                exp_word = expected_hsv.pop_front();
                if (hsv.hue !== exp_word.hue)
                begin
                    $display("%0t: hue expected %0d actual %0d", $time, exp_word.hue, hsv.hue);
                    error_count++;
                end
                if (hsv.saturation !== exp_word.saturation)
                begin
                    $display("%0t: saturation expected %0d actual %0d", $time,
                             exp_word.saturation, hsv.saturation);
                    error_count++;
                end
                if (hsv.brightness !== exp_word.brightness)
                begin
                    $display("%0t: brightness expected %0d actual %0d", $time,
                             exp_word.brightness, hsv.brightness);
                    error_count++;
                end
                if (hsv.hue_undefined !== exp_word.hue_undefined)
                begin
                    $display("%0t: hue_undefined expected %0d actual %0d", $time,
                             exp_word.hue_undefined, hsv.hue_undefined);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // offer one pixel, optionally after random idle cycles, wait for acceptance
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            pixel <= pixel_t'(24'($urandom));
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        expected_hsv.push_back(convert_pixel(px));
    endtask

    task automatic go_idle();
        pixel_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_hsv.size() != 0)
            @(posedge clk);
    endtask

    // extremes, grays, ties and hue wrap cases
    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd254, 8'd253, 8'd255);
        send_pixel(8'd200, 8'd10, 8'd100);
        send_pixel(8'd10, 8'd200, 8'd100);
        send_pixel(8'd10, 8'd100, 8'd200);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd255, 8'd1, 8'd0);
        wait_drained();
    endtask

    // random pixels, some with tied or near channels
    task automatic test_random(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            case ($urandom_range(5))
                0: g = r;
                1: b = r;
                2: b = g;
                3: begin g = r; b = r; end
                4: begin g = r ^ 8'($urandom_range(3)); b = r ^ 8'($urandom_range(3)); end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // receiver holds off while pixels keep coming, then drains
    task automatic test_backpressure();
        int saved;
        saved = send_idle_pct;
        send_idle_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
        send_idle_pct = saved;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        hold_off = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 23;
        recv_stall_pct = 52;
        test_random(700);
        wait_drained();
        send_idle_pct = 52;
        recv_stall_pct = 23;
        test_random(700);
        test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(600);
        wait_drained();
        repeat (LATENCY + 5) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/rth_pkg.sv
sv/rth_prep.sv
sv/rth_div.sv
sv/rgb_to_hsv.sv
sv/rth_checker.sv
test/tb.sv
